@@ sv/sobel_gradient_magnitude_top_assert.svh @@
// Assertion macros for the Sobel gradient magnitude block.
// Used by the port checker; expects signals named clk and rst in scope.
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SGM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgm assertion failed");

// Next-cycle implication, ignored while reset is high.
`define SGM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgm assertion failed");

`endif

@@ sv/sgm_pkg.sv @@
// Shared constants, types and command/status structs for the Sobel block.
// No dependencies; imported by sgm_ctrl, sgm_dp and the top level.
package sgm_pkg;

  localparam int MAX_ROW_BYTES = 4096;
  localparam int MAX_CHANNELS  = 4;
  localparam int MAX_ROWS      = 4096;
  localparam int WIN_COLS      = 2 * MAX_CHANNELS + 1;

  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int PEND_W = COL_W + 2;
  localparam int ADDR_W = 4;

  localparam logic [2:0]  CHAN_LIMIT = 3'(MAX_CHANNELS);
  localparam logic [12:0] ROWS_LIMIT = 13'(MAX_ROWS);
  localparam logic [15:0] BYTES_LIMIT = 16'(MAX_ROW_BYTES);

  localparam logic [20:0] SAT_LIMIT = 21'd64770;
  localparam logic [7:0]  SAT_MAG   = 8'd255;

  localparam logic [12:0] RST_WIDTH    = 13'd640;
  localparam logic [2:0]  RST_CHANNELS = 3'd1;
  localparam logic [12:0] RST_HEIGHT   = 13'd480;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_NONE     = 2'd3
  } sgm_reg_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       dec;
    logic       clr_mag;
    logic       grad;
    logic       sqx;
    logic       sqy;
    logic       root;
    logic [2:0] root_bit;
    logic       round;
    logic       emit;
    logic       emit_err;
  } sgm_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic cfg_bad;
    logic pend_zero;
    logic need_out;
    logic interior;
    logic out_free;
  } sgm_stat_t;

endpackage

@@ sv/sgm_in_if.sv @@
// Input channel: pixel bytes and drain ticks with a valid/ready handshake.
// Depends on nothing.
interface sgm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel_byte;

  modport source (output valid, output kind, output pixel_byte, input ready);
  modport sink   (input valid, input kind, input pixel_byte, output ready);
endinterface

@@ sv/sgm_out_if.sv @@
// Result channel: gradient magnitude with frame and error flags.
// Depends on nothing.
interface sgm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] magnitude;
  logic       end_of_frame;
  logic       config_error;

  modport source (output valid, output magnitude, output end_of_frame,
                  output config_error, input ready);
  modport sink   (input valid, input magnitude, input end_of_frame,
                  input config_error, output ready);
endinterface

@@ sv/sgm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sgm_ctrl.sv @@
// Controller state machine: sequences one item through the datapath.
// Depends on sgm_pkg for the command and status structs.
module sgm_ctrl import sgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sgm_stat_t stat,
  output sgm_cmd_t  cmd,
  output logic      in_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DECIDE, S_DRAIN, S_GRAD, S_SQX, S_SQY,
    S_ROOT, S_ROUND, S_DONE, S_DONE_ERR
  } state_t;

  state_t     state;
  logic [2:0] bit_idx;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_ready && stat.in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (stat.cfg_bad) begin
              state <= S_DONE_ERR;
            end else if (stat.in_kind == KIND_DRAIN) begin
              state <= S_DRAIN;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD:   state <= S_DECIDE;
        S_DECIDE: begin
          if (!stat.need_out) begin
            state <= S_IDLE;
          end else if (stat.interior) begin
            state <= S_GRAD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DRAIN:  state <= stat.pend_zero ? S_IDLE : S_DONE;
        S_GRAD:   state <= S_SQX;
        S_SQX:    state <= S_SQY;
        S_SQY: begin
          state   <= S_ROOT;
          bit_idx <= 3'd7;
        end
        S_ROOT: begin
          bit_idx <= bit_idx - 3'd1;
          if (bit_idx == 3'd0) begin
            state <= S_ROUND;
          end
        end
        S_ROUND:  state <= S_DONE;
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_DONE_ERR: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.root_bit = bit_idx;
    cmd.take     = accept;
    unique case (state)
      S_LOAD:     cmd.load = 1'b1;
      S_DECIDE: begin
        cmd.dec     = stat.need_out;
        cmd.clr_mag = stat.need_out && !stat.interior;
      end
      S_DRAIN: begin
        cmd.dec     = !stat.pend_zero;
        cmd.clr_mag = !stat.pend_zero;
      end
      S_GRAD:     cmd.grad  = 1'b1;
      S_SQX:      cmd.sqx   = 1'b1;
      S_SQY:      cmd.sqy   = 1'b1;
      S_ROOT:     cmd.root  = 1'b1;
      S_ROUND:    cmd.round = 1'b1;
      S_DONE:     cmd.emit  = stat.out_free;
      S_DONE_ERR: begin
        cmd.emit     = stat.out_free;
        cmd.emit_err = 1'b1;
      end
      default:    cmd = cmd;
    endcase
  end

endmodule

@@ sv/sgm_dp.sv @@
// Datapath: configuration registers, line stores, 3x9 window, positions,
// gradient, square-root unit and result register. Uses sgm_pkg and sgm_ram.
module sgm_dp import sgm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sgm_cmd_t          cmd,
  output sgm_stat_t         stat,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_mag,
  output logic              out_eof,
  output logic              out_err,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata
);

  logic [12:0] width_q;
  logic [2:0]  chan_q;
  logic [12:0] height_q;

  logic [15:0] row_len;
  logic [15:0] lag;
  logic        cfg_wr;
  sgm_reg_t    reg_idx;

  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [PEND_W-1:0] pending;

  logic [7:0] byte_q;
  logic [7:0] top_rd;
  logic [7:0] mid_rd;
  logic [7:0] win [3][WIN_COLS];

  logic [9:0]  ax;
  logic [9:0]  ay;
  logic [20:0] g2;
  logic [7:0]  root_n;
  logic [7:0]  mag;

  logic [7:0]  tl, tc, tr, ml, mr, bl, bc, br;
  logic signed [11:0] gx, gy;
  logic [7:0]  trial;
  logic [16:0] n_sq_n;
  logic        out_last;

  assign row_len = 16'(width_q) * 16'(chan_q);
  assign lag     = row_len + 16'(chan_q);
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = sgm_reg_t'(paddr[3:2]);

  assign stat.in_valid  = in_valid;
  assign stat.in_kind   = in_kind;
  assign stat.cfg_bad   = (width_q == '0) || (chan_q == '0) || (height_q == '0) ||
                          (chan_q > CHAN_LIMIT) || (height_q > ROWS_LIMIT) ||
                          (row_len > BYTES_LIMIT);
  assign stat.pend_zero = (pending == '0);
  assign stat.need_out  = (16'(pending) > lag);
  assign stat.interior  = (out_row != '0) && (13'(out_row) + 13'd1 < height_q) &&
                          (16'(out_col) >= 16'(chan_q)) &&
                          (16'(out_col) + 16'(chan_q) < row_len);
  assign stat.out_free  = !out_valid || out_ready;

  assign out_last = (13'(out_row) == height_q - 13'd1) &&
                    (16'(out_col) == row_len - 16'd1);

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WIDTH:    prdata = 32'(width_q);
      REG_CHANNELS: prdata = 32'(chan_q);
      REG_HEIGHT:   prdata = 32'(height_q);
      REG_NONE:     prdata = '0;
    endcase
  end

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES)) u_upper (
    .clk(clk), .we(cmd.load), .waddr(in_col), .wdata(mid_rd),
    .raddr(in_col), .rdata(top_rd)
  );

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES)) u_middle (
    .clk(clk), .we(cmd.load), .waddr(in_col), .wdata(byte_q),
    .raddr(in_col), .rdata(mid_rd)
  );

  // Taps of the 3x3 neighbourhood; horizontal spacing is the channel count.
  always_comb begin
    tl = '0; tc = '0; tr = '0; ml = '0; mr = '0; bl = '0; bc = '0; br = '0;
    for (int k = 1; k <= MAX_CHANNELS; k++) begin
      if (chan_q == 3'(k)) begin
        tr = win[0][WIN_COLS-1];
        tc = win[0][WIN_COLS-1-k];
        tl = win[0][WIN_COLS-1-2*k];
        mr = win[1][WIN_COLS-1];
        ml = win[1][WIN_COLS-1-2*k];
        br = win[2][WIN_COLS-1];
        bc = win[2][WIN_COLS-1-k];
        bl = win[2][WIN_COLS-1-2*k];
      end
    end
    gx = (12'(tr) + {3'b0, mr, 1'b0} + 12'(br)) - (12'(tl) + {3'b0, ml, 1'b0} + 12'(bl));
    gy = (12'(bl) + {3'b0, bc, 1'b0} + 12'(br)) - (12'(tl) + {3'b0, tc, 1'b0} + 12'(tr));
    trial  = root_n | (8'd1 << cmd.root_bit);
    n_sq_n = 17'(root_n) * 17'(root_n) + 17'(root_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q   <= RST_WIDTH;
      chan_q    <= RST_CHANNELS;
      height_q  <= RST_HEIGHT;
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < WIN_COLS; k++) begin
          win[r][k] <= '0;
        end
      end
    end else if (cfg_wr && reg_idx != REG_NONE) begin
      unique case (reg_idx)
        REG_WIDTH:    width_q  <= pwdata[12:0];
        REG_CHANNELS: chan_q   <= pwdata[2:0];
        REG_HEIGHT:   height_q <= pwdata[12:0];
        REG_NONE:     width_q  <= width_q;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < WIN_COLS; k++) begin
          win[r][k] <= '0;
        end
      end
    end else begin
      if (cmd.take) begin
        byte_q <= in_byte;
      end
      if (cmd.load) begin
        for (int k = 0; k < WIN_COLS - 1; k++) begin
          win[0][k] <= win[0][k+1];
          win[1][k] <= win[1][k+1];
          win[2][k] <= win[2][k+1];
        end
        win[0][WIN_COLS-1] <= top_rd;
        win[1][WIN_COLS-1] <= mid_rd;
        win[2][WIN_COLS-1] <= byte_q;
        pending <= pending + 1'b1;
        if (16'(in_col) + 16'd1 >= row_len) begin
          in_col <= '0;
          in_row <= (13'(in_row) + 13'd1 >= height_q) ? '0 : in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.dec) begin
        pending <= pending - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_mag   <= cmd.emit_err ? 8'd0 : mag;
        out_eof   <= !cmd.emit_err && out_last;
        out_err   <= cmd.emit_err;
        if (!cmd.emit_err) begin
          if (16'(out_col) + 16'd1 >= row_len) begin
            out_col <= '0;
            out_row <= (13'(out_row) + 13'd1 >= height_q) ? '0 : out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Gradient, squares and square root; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.clr_mag) begin
      mag <= '0;
    end
    if (cmd.grad) begin
      ax <= 10'(gx < 0 ? -gx : gx);
      ay <= 10'(gy < 0 ? -gy : gy);
    end
    if (cmd.sqx) begin
      g2 <= 21'(ax) * 21'(ax);
    end
    if (cmd.sqy) begin
      g2     <= g2 + 21'(ay) * 21'(ay);
      root_n <= '0;
    end
    if (cmd.root) begin
      if (16'(trial) * 16'(trial) <= g2[15:0]) begin
        root_n <= trial;
      end
    end
    if (cmd.round) begin
      if (g2 > SAT_LIMIT) begin
        mag <= SAT_MAG;
      end else begin
        mag <= root_n + 8'((g2 > 21'(n_sq_n)) ? 1 : 0);
      end
    end
  end

endmodule

@@ sv/sobel_gradient_magnitude_top.sv @@
// Sobel 3x3 gradient magnitude over a channel-interleaved byte stream.
// One item is accepted on pix_in when valid and ready are both high; each
// transfer carries a pixel byte or a drain tick. At most one result leaves
// on res_out per item, in order, through a one-deep output register.
// A pixel byte is loaded into the window and line stores and then either
// yields no result, or an interior magnitude (gradient, two squaring steps,
// an eight-step bit-by-bit square root and a rounding step), or a border
// result. A drain tick flushes a result or, when nothing is owed, none;
// items seen under a bad configuration yield an error result. The
// controller handles one item at a time and takes no new item until it is
// done with the last one.
// Results lag the pixel stream by one row plus one pixel; drain ticks
// flush what is still owed, with magnitude zero.
// Synchronous reset restores the default geometry (640 x 480, one channel)
// and clears positions, window and the output valid flag; the line stores
// are not cleared, and need no clearing pass. A register write over the
// APB port restarts the frame. If the receiver stalls, the finished result
// waits in the output register and the next item is still taken in; the
// block then waits with its following result until the register frees.
// Dependencies: sgm_pkg, sgm_in_if, sgm_out_if, sgm_ctrl, sgm_dp, sgm_ram.
module sobel_gradient_magnitude_top import sgm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sgm_in_if.sink            pix_in,
  sgm_out_if.source         res_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sgm_cmd_t  cmd;
  sgm_stat_t stat;
  logic      in_ready;

  // Writes complete in their access cycle, so the port never waits.
  assign pready       = 1'b1;
  assign pix_in.ready = in_ready;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  sgm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (pix_in.valid),
    .in_kind   (pix_in.kind),
    .in_byte   (pix_in.pixel_byte),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_mag   (res_out.magnitude),
    .out_eof   (res_out.end_of_frame),
    .out_err   (res_out.config_error),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule

@@ sv/sgm_checker.sv @@
// Port-level checker for the Sobel block, bound to the top level.
// Depends on sobel_gradient_magnitude_top_assert.svh.
`include "sobel_gradient_magnitude_top_assert.svh"

module sgm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_mag,
  input logic       out_eof,
  input logic       out_err
);

  `SGM_ASSERT_IMP(a_err_zero, out_valid && out_err, out_mag == 8'd0 && !out_eof)
  `SGM_ASSERT_IMP(a_eof_no_err, out_valid && out_eof, !out_err)
  `SGM_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SGM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mag))

endmodule

bind sobel_gradient_magnitude_top sgm_checker u_sgm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_mag   (res_out.magnitude),
  .out_eof   (res_out.end_of_frame),
  .out_err   (res_out.config_error)
);
